FILE: sv/packet_airtime_calc_defines.svh
// assertion macros for the packet airtime calculator
// no dependencies; expects clk and rst_n in the including module

`ifndef PACKET_AIRTIME_CALC_DEFINES_SVH
`define PACKET_AIRTIME_CALC_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PAT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("packet_airtime_calc: same-cycle check failed");

// next-cycle implication, disabled during reset
`define PAT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("packet_airtime_calc: next-cycle check failed");

`endif

FILE: sv/pat_pkg.sv
// shared types and constants for the packet airtime calculator
// no dependencies; used by the interfaces, pat_air_scale and the top level

package pat_pkg;

    localparam int PL_W      = 8;
    localparam int CODE_W    = 4;
    localparam int SF_W      = 4;
    localparam int CR_W      = 3;
    localparam int SYMS_W    = 11;
    localparam int AIR_W     = 36;
    localparam int RATE_W    = 16;
    localparam int BW_W      = 19;
    localparam int PRE_W     = 16;
    localparam int X_W       = 31;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_VAL_W = 16;
    localparam int BW_CODES  = 10;

    // bandwidth in hz for each code
    localparam logic [BW_W-1:0] BW_HZ [BW_CODES] = '{
        19'd7812,  19'd10417,  19'd15625,  19'd20833,  19'd31250,
        19'd41667, 19'd62500,  19'd125000, 19'd250000, 19'd500000
    };

    localparam logic [SF_W-1:0] SF_MIN = 4'd5;
    localparam logic [SF_W-1:0] SF_MAX = 4'd12;
    localparam logic [CR_W-1:0] CR_MIN = 3'd1;
    localparam logic [CR_W-1:0] CR_MAX = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_ON     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPLICIT   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_RATE   = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_SF = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_CR = 8'd5;

    typedef struct packed {
        logic [PL_W-1:0]   payload_bytes;
        logic [CODE_W-1:0] bw_code;
        logic              has_request;
        logic [SF_W-1:0]   req_sf;
        logic [CR_W-1:0]   req_cr;
    } pat_in_t;

    typedef struct packed {
        logic [SYMS_W-1:0] payload_symbols;
        logic [AIR_W-1:0]  airtime_us;
        logic [RATE_W-1:0] bitrate_bps;
        logic [BW_W-1:0]   bandwidth_hz;
    } pat_out_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_VAL_W-1:0] value;
    } pat_cfg_t;

endpackage

FILE: sv/pat_ifs.sv
// valid/ready channel interfaces for packet items, results and register writes
// depends on pat_pkg for the payload types

interface pat_in_if
    import pat_pkg::*;
();
    logic    valid;
    logic    ready;
    pat_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pat_out_if
    import pat_pkg::*;
();
    logic     valid;
    logic     ready;
    pat_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pat_cfg_if
    import pat_pkg::*;
();
    logic     valid;
    logic     ready;
    pat_cfg_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/pat_air_scale.sv
// two-stage scaling of quarter-symbol chip time to microseconds
// depends on pat_pkg (bandwidth table, widths)

module pat_air_scale
    import pat_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [X_W-1:0]    x,
    input  logic [CODE_W-1:0] code,
    output logic [AIR_W-1:0]  airtime
);

    localparam int RECIP_SHIFT = 50;
    localparam int HALF_W      = 28;
    localparam int RECIP_W     = 2 * HALF_W;
    localparam int PROD_W      = X_W + HALF_W;
    localparam int SUM_W       = PROD_W + HALF_W;

    // 250000 * 2^50, scale for x * 1e6 / (4 * bw)
    localparam logic [71:0] AIR_SCALE = 72'd250000 << RECIP_SHIFT;

    // ceil(AIR_SCALE / bw), exact floor for every x below 2^31
    localparam logic [RECIP_W-1:0] AIR_RECIP [BW_CODES] = '{
        RECIP_W'((AIR_SCALE + 72'(BW_HZ[0]) - 72'd1) / 72'(BW_HZ[0])),
        RECIP_W'((AIR_SCALE + 72'(BW_HZ[1]) - 72'd1) / 72'(BW_HZ[1])),
        RECIP_W'((AIR_SCALE + 72'(BW_HZ[2]) - 72'd1) / 72'(BW_HZ[2])),
        RECIP_W'((AIR_SCALE + 72'(BW_HZ[3]) - 72'd1) / 72'(BW_HZ[3])),
        RECIP_W'((AIR_SCALE + 72'(BW_HZ[4]) - 72'd1) / 72'(BW_HZ[4])),
        RECIP_W'((AIR_SCALE + 72'(BW_HZ[5]) - 72'd1) / 72'(BW_HZ[5])),
        RECIP_W'((AIR_SCALE + 72'(BW_HZ[6]) - 72'd1) / 72'(BW_HZ[6])),
        RECIP_W'((AIR_SCALE + 72'(BW_HZ[7]) - 72'd1) / 72'(BW_HZ[7])),
        RECIP_W'((AIR_SCALE + 72'(BW_HZ[8]) - 72'd1) / 72'(BW_HZ[8])),
        RECIP_W'((AIR_SCALE + 72'(BW_HZ[9]) - 72'd1) / 72'(BW_HZ[9]))
    };

    logic               bad;
    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  p_lo_next, p_hi_next;
    logic [PROD_W-1:0]  p_lo_reg, p_hi_reg;
    logic               bad_reg;
    logic [SUM_W-1:0]   sum;
    logic [AIR_W-1:0]   airtime_next;
    logic [AIR_W-1:0]   airtime_reg;

    // partial products against the two halves of the reciprocal
    always_comb
    begin
        bad       = (code >= CODE_W'(BW_CODES));
        recip     = bad ? '0 : AIR_RECIP[code];
        p_lo_next = PROD_W'(x) * PROD_W'(recip[HALF_W-1:0]);
        p_hi_next = PROD_W'(x) * PROD_W'(recip[RECIP_W-1:HALF_W]);
    end

    always_comb
    begin
        sum          = {p_hi_reg, {HALF_W{1'b0}}} + SUM_W'(p_lo_reg);
        airtime_next = bad_reg ? '1 : sum[RECIP_SHIFT+AIR_W-1:RECIP_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_lo_reg    <= p_lo_next;
            p_hi_reg    <= p_hi_next;
            bad_reg     <= bad;
            airtime_reg <= airtime_next;
        end
    end

    assign airtime = airtime_reg;

endmodule

FILE: sv/packet_airtime_calc.sv
// top level of the packet airtime calculator: config registers and pipeline
// depends on pat_pkg, pat_ifs.sv, pat_air_scale and the assertion macros
//
//   channel  dir  payload                                       accepted when
//   cfg      in   index, value                                  valid && ready
//   pkt      in   payload_bytes, bw_code, has_request, sf, cr   valid && ready
//   res      out  payload_symbols, airtime_us, bitrate_bps, bw  valid && ready
//
// one item per cycle sustained while res is not stalled; each item passes through
// six register stages from accept to result, the last two the airtime multiply and sum
// cfg is always ready; writes take effect in the next cycle and must come while idle
// rst_n clears the valid bits and loads the register defaults
// a stalled result freezes every stage at once, so pkt.ready follows res.ready while a result is valid

`include "packet_airtime_calc_defines.svh"

module packet_airtime_calc
    import pat_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pat_cfg_if.sink   cfg,
    pat_in_if.sink    pkt,
    pat_out_if.source res
);

    localparam int NSTG = 6;

    // reciprocal of k = sf - 2*ldro, ceil(2^16 / k), exact for m below 2^10
    function automatic logic [14:0] recip_k(input logic [SF_W-1:0] k);
        logic [14:0] r;
        case (k)
            4'd3:    r = 15'd21846;
            4'd4:    r = 15'd16384;
            4'd5:    r = 15'd13108;
            4'd6:    r = 15'd10923;
            4'd7:    r = 15'd9363;
            4'd8:    r = 15'd8192;
            4'd9:    r = 15'd7282;
            4'd10:   r = 15'd6554;
            4'd11:   r = 15'd5958;
            4'd12:   r = 15'd5462;
            default: r = 15'd0;
        endcase
        return r;
    endfunction

    // reciprocal of cr+4, ceil(2^22 / d), exact for dividends below 2^19
    function automatic logic [19:0] recip_d(input logic [3:0] d);
        logic [19:0] r;
        case (d)
            4'd5:    r = 20'd838861;
            4'd6:    r = 20'd699051;
            4'd7:    r = 20'd599187;
            4'd8:    r = 20'd524288;
            default: r = 20'd0;
        endcase
        return r;
    endfunction

    // handshake and pipeline control
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic            adv;

    // configuration registers
    logic [PRE_W-1:0] pre_reg;
    logic             crc_reg;
    logic             exh_reg;
    logic             ldro_reg;
    logic [SF_W-1:0]  dsf_reg;
    logic [CR_W-1:0]  dcr_reg;

    // stage 1: resolved parameters, ceiling dividend, bit rate numerator
    logic [SF_W-1:0]   sf_raw, sf_c, k;
    logic [CR_W-1:0]   cr_raw, cr_c;
    logic signed [12:0] num;
    logic [12:0]       num_adj;
    logic [22:0]       sfbw;
    logic [9:0]        s1_m_next, s1_m_reg;
    logic [14:0]       s1_rk_next, s1_rk_reg;
    logic              s1_pos_next, s1_pos_reg;
    logic [3:0]        s1_cr4_next, s1_cr4_reg;
    logic [SF_W-1:0]   s1_sf_reg;
    logic [CODE_W-1:0] s1_code_reg;
    logic [BW_W-1:0]   s1_bw_next, s1_bw_reg;
    logic [24:0]       s1_rn_next, s1_rn_reg;

    // stage 2: ceiling quotient and bit rate
    logic [24:0]       prod_q;
    logic [18:0]       rate_m;
    logic [38:0]       prod_r;
    logic [7:0]        s2_q_next, s2_q_reg;
    logic [RATE_W-1:0] s2_rate_next, s2_rate_reg;
    logic              s2_pos_reg;
    logic [3:0]        s2_cr4_reg;
    logic [SF_W-1:0]   s2_sf_reg;
    logic [CODE_W-1:0] s2_code_reg;
    logic [BW_W-1:0]   s2_bw_reg;

    // stage 3: payload symbol count
    logic [SYMS_W-1:0] s3_syms_next, s3_syms_reg;
    logic [SF_W-1:0]   s3_sf_reg;
    logic [CODE_W-1:0] s3_code_reg;
    logic [BW_W-1:0]   s3_bw_reg;
    logic [RATE_W-1:0] s3_rate_reg;

    // stage 4: quarter symbols scaled to chips
    logic [18:0]       quarters;
    logic [X_W-1:0]    s4_x_next, s4_x_reg;
    logic [CODE_W-1:0] s4_code_reg;
    logic [SYMS_W-1:0] s4_syms_reg;
    logic [BW_W-1:0]   s4_bw_reg;
    logic [RATE_W-1:0] s4_rate_reg;

    // stages 5 and 6 ride alongside the airtime scaler
    logic [SYMS_W-1:0] s5_syms_reg, s6_syms_reg;
    logic [BW_W-1:0]   s5_bw_reg, s6_bw_reg;
    logic [RATE_W-1:0] s5_rate_reg, s6_rate_reg;
    logic [AIR_W-1:0]  airtime;

    // every stage moves together unless the result is held
    assign adv       = !vld_reg[NSTG-1] || res.ready;
    assign pkt.ready = adv;
    assign cfg.ready = 1'b1;
    assign vld_next  = {vld_reg[NSTG-2:0], pkt.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_reg  <= 16'd8;
            crc_reg  <= 1'b1;
            exh_reg  <= 1'b1;
            ldro_reg <= 1'b0;
            dsf_reg  <= 4'd7;
            dcr_reg  <= 3'd1;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.data.index)
                REG_PREAMBLE:   pre_reg  <= cfg.data.value;
                REG_CRC_ON:     crc_reg  <= cfg.data.value[0];
                REG_EXPLICIT:   exh_reg  <= cfg.data.value[0];
                REG_LOW_RATE:   ldro_reg <= cfg.data.value[0];
                REG_DEFAULT_SF: dsf_reg  <= cfg.data.value[SF_W-1:0];
                REG_DEFAULT_CR: dcr_reg  <= cfg.data.value[CR_W-1:0];
                default:        ;
            endcase
        end
    end

    // stage 1 logic
    always_comb
    begin
        sf_raw = pkt.data.has_request ? pkt.data.req_sf : dsf_reg;
        cr_raw = pkt.data.has_request ? pkt.data.req_cr : dcr_reg;
        // saturate out-of-range sf and cr
        sf_c = (sf_raw < SF_MIN) ? SF_MIN : ((sf_raw > SF_MAX) ? SF_MAX : sf_raw);
        cr_c = (cr_raw < CR_MIN) ? CR_MIN : ((cr_raw > CR_MAX) ? CR_MAX : cr_raw);
        k    = sf_c - {2'b00, ldro_reg, 1'b0};

        // 8*pl - 4*sf + 28 + 16*crc - 20*implicit, range -40..2064
        num = $signed({2'b00, pkt.data.payload_bytes, 3'b000})
            - $signed({7'b0, sf_c, 2'b00})
            + 13'sd28
            + (crc_reg ? 13'sd16 : 13'sd0)
            - (exh_reg ? 13'sd0 : 13'sd20);
        s1_pos_next = (num > 13'sd0);

        // ceil(num / 4k) = floor(floor((num + 4k - 1) / 4) / k)
        num_adj    = $unsigned(num) + {7'b0, k, 2'b00} - 13'd1;
        s1_m_next  = num_adj[11:2];
        s1_rk_next = recip_k(k);
        s1_cr4_next = {1'b0, cr_c} + 4'd4;

        s1_bw_next = (pkt.data.bw_code < CODE_W'(BW_CODES)) ? BW_HZ[pkt.data.bw_code] : '0;
        sfbw       = {19'b0, sf_c} * 23'(s1_bw_next);
        s1_rn_next = {sfbw, 2'b00};
    end

    // stage 2 logic
    always_comb
    begin
        prod_q       = 25'(s1_m_reg) * 25'(s1_rk_reg);
        s2_q_next    = prod_q[23:16];
        // sf*bw*4 / ((cr+4) * 2^sf): shift out 2^sf, then divide by cr+4
        rate_m       = 19'(s1_rn_reg >> s1_sf_reg);
        prod_r       = 39'(rate_m) * 39'(recip_d(s1_cr4_reg));
        s2_rate_next = prod_r[37:22];
    end

    // stage 3 logic
    assign s3_syms_next = s2_pos_reg ? (11'd8 + 11'(12'(s2_q_reg) * 12'(s2_cr4_reg)))
                                     : 11'd8;

    // stage 4 logic: 4*preamble + 17 + 4*symbols quarter symbols, times 2^sf
    always_comb
    begin
        quarters  = 19'({pre_reg, 2'b00}) + 19'd17 + 19'({s3_syms_reg, 2'b00});
        s4_x_next = X_W'(quarters) << s3_sf_reg;
    end

    // pipeline payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_m_reg    <= s1_m_next;
            s1_rk_reg   <= s1_rk_next;
            s1_pos_reg  <= s1_pos_next;
            s1_cr4_reg  <= s1_cr4_next;
            s1_sf_reg   <= sf_c;
            s1_code_reg <= pkt.data.bw_code;
            s1_bw_reg   <= s1_bw_next;
            s1_rn_reg   <= s1_rn_next;

            s2_q_reg    <= s2_q_next;
            s2_rate_reg <= s2_rate_next;
            s2_pos_reg  <= s1_pos_reg;
            s2_cr4_reg  <= s1_cr4_reg;
            s2_sf_reg   <= s1_sf_reg;
            s2_code_reg <= s1_code_reg;
            s2_bw_reg   <= s1_bw_reg;

            s3_syms_reg <= s3_syms_next;
            s3_sf_reg   <= s2_sf_reg;
            s3_code_reg <= s2_code_reg;
            s3_bw_reg   <= s2_bw_reg;
            s3_rate_reg <= s2_rate_reg;

            s4_x_reg    <= s4_x_next;
            s4_code_reg <= s3_code_reg;
            s4_syms_reg <= s3_syms_reg;
            s4_bw_reg   <= s3_bw_reg;
            s4_rate_reg <= s3_rate_reg;

            s5_syms_reg <= s4_syms_reg;
            s5_bw_reg   <= s4_bw_reg;
            s5_rate_reg <= s4_rate_reg;

            s6_syms_reg <= s5_syms_reg;
            s6_bw_reg   <= s5_bw_reg;
            s6_rate_reg <= s5_rate_reg;
        end
    end

    // stages 5 and 6: chips * 1e6 / (4*bw), saturated for unknown codes
    pat_air_scale u_air_scale (
        .clk     (clk),
        .en      (adv),
        .x       (s4_x_reg),
        .code    (s4_code_reg),
        .airtime (airtime)
    );

    // result register is the last stage
    assign res.valid                = vld_reg[NSTG-1];
    assign res.data.payload_symbols = s6_syms_reg;
    assign res.data.airtime_us      = airtime;
    assign res.data.bitrate_bps     = s6_rate_reg;
    assign res.data.bandwidth_hz    = s6_bw_reg;

    // a held result freezes the whole pipe
    `PAT_ASSERT_NEXT(a_stall_freezes, !adv, $stable(vld_reg))
    // an accepted item always occupies the first stage
    `PAT_ASSERT_NEXT(a_accept_enters, pkt.valid && pkt.ready, vld_reg[0])
    // unknown bandwidth code: airtime saturated and bit rate zero
    `PAT_ASSERT_NOW(a_bad_bw_sat, res.valid && res.data.bandwidth_hz == '0, res.data.airtime_us == '1 && res.data.bitrate_bps == '0)
    // symbol count never drops below the base eight
    `PAT_ASSERT_NOW(a_syms_floor, vld_reg[2], s3_syms_reg >= 11'd8)

endmodule
